[rtl/homp_pkg.sv]
// ----------------------------------------------------------------------------
// homp_pkg: shared types and constants of the homography point mapper.
// Holds coefficient and result widths, register indexes and control structs.
// ----------------------------------------------------------------------------
package homp_pkg;

   localparam int COEF_W         = 48;
   localparam int OUT_W          = 32;
   localparam int OUT_FRAC       = 24;
   localparam int SAT_SHIFT      = OUT_W - OUT_FRAC;
   localparam int DIV_STEPS      = OUT_W;
   localparam int NUM_COEF       = 8;
   localparam int CSR_IDX_W      = 3;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_M00 = 3'd0,
      CSR_M01 = 3'd1,
      CSR_M02 = 3'd2,
      CSR_M10 = 3'd3,
      CSR_M11 = 3'd4,
      CSR_M12 = 3'd5,
      CSR_M20 = 3'd6,
      CSR_M21 = 3'd7
   } csr_idx_type;

   // Per-channel control that rides along with the quotient.
   typedef struct packed {
      logic neg;
      logic sat;
   } homp_ctl_type;

   // Per-point flags.
   typedef struct packed {
      logic in_square;
      logic bad;
   } homp_flags_type;

endpackage

[rtl/homp_front.sv]
// ----------------------------------------------------------------------------
// homp_front: products, sums and divider setup.
// Four register stages: multiply, accumulate, magnitude, compare and setup.
// ----------------------------------------------------------------------------
module homp_front #(
   parameter int COORD_BITS = homp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = homp_pkg::FRAC_BITS_DEF,
   parameter int SUM_W      = homp_pkg::COEF_W + COORD_BITS + 2
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   in_valid,
   input  logic signed [COORD_BITS-1:0]                           in_px,
   input  logic signed [COORD_BITS-1:0]                           in_py,
   input  logic [homp_pkg::NUM_COEF-1:0][homp_pkg::COEF_W-1:0]    coef,
   output logic                                                   out_valid,
   output logic [SUM_W-1:0]                                       out_ru,
   output logic [SUM_W-1:0]                                       out_rv,
   output logic [SUM_W-1:0]                                       out_den,
   output logic [homp_pkg::OUT_W-1:0]                             out_lqu,
   output logic [homp_pkg::OUT_W-1:0]                             out_lqv,
   output homp_pkg::homp_ctl_type                                 out_ctl_u,
   output homp_pkg::homp_ctl_type                                 out_ctl_v,
   output homp_pkg::homp_flags_type                               out_flags
);

   localparam int PROD_W = homp_pkg::COEF_W + COORD_BITS;
   localparam int SH     = homp_pkg::SAT_SHIFT;
   localparam int FR     = homp_pkg::OUT_FRAC;
   localparam logic signed [SUM_W-1:0] ONE_W = SUM_W'(1) << FRAC_BITS;

   // Stage 1: six products and the two constant terms.
   logic                      v1_ff;
   logic signed [PROD_W-1:0]  p_ff [6];
   logic signed [homp_pkg::COEF_W-1:0] cu_ff, cv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      p_ff[0] <= $signed(coef[homp_pkg::CSR_M00]) * in_px;
      p_ff[1] <= $signed(coef[homp_pkg::CSR_M01]) * in_py;
      p_ff[2] <= $signed(coef[homp_pkg::CSR_M10]) * in_px;
      p_ff[3] <= $signed(coef[homp_pkg::CSR_M11]) * in_py;
      p_ff[4] <= $signed(coef[homp_pkg::CSR_M20]) * in_px;
      p_ff[5] <= $signed(coef[homp_pkg::CSR_M21]) * in_py;
      cu_ff   <= $signed(coef[homp_pkg::CSR_M02]);
      cv_ff   <= $signed(coef[homp_pkg::CSR_M12]);
   end

   // Stage 2: numerators and denominator, exact.
   logic                     v2_ff;
   logic signed [SUM_W-1:0]  nu_ff, nv_ff, w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      nu_ff <= SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]) + SUM_W'(cu_ff);
      nv_ff <= SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]) + SUM_W'(cv_ff);
      w_ff  <= SUM_W'(p_ff[4]) + SUM_W'(p_ff[5]) + ONE_W;
   end

   // Stage 3: magnitudes and signs.
   logic              v3_ff;
   logic [SUM_W-1:0]  mu_ff, mv_ff, mw_ff;
   logic              su_ff, sv_ff, sw_ff, nzu_ff, nzv_ff, zw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      mu_ff  <= nu_ff[SUM_W-1] ? SUM_W'(-nu_ff) : SUM_W'(nu_ff);
      mv_ff  <= nv_ff[SUM_W-1] ? SUM_W'(-nv_ff) : SUM_W'(nv_ff);
      mw_ff  <= w_ff[SUM_W-1]  ? SUM_W'(-w_ff)  : SUM_W'(w_ff);
      su_ff  <= nu_ff[SUM_W-1];
      sv_ff  <= nv_ff[SUM_W-1];
      sw_ff  <= w_ff[SUM_W-1];
      nzu_ff <= (nu_ff != '0);
      nzv_ff <= (nv_ff != '0);
      zw_ff  <= (w_ff == '0);
   end

   // Stage 4: saturation and unit-square tests, divider setup.
   // The quotient fits in OUT_W bits exactly when |n| < |w| * 2^SH.
   logic [SUM_W+SH-1:0] den_sh;
   logic                in_u, in_v;

   always_comb begin
      den_sh = {mw_ff, SH'(0)};
      in_u   = (!nzu_ff || (su_ff == sw_ff)) && (mw_ff >= mu_ff);
      in_v   = (!nzv_ff || (sv_ff == sw_ff)) && (mw_ff >= mv_ff);
   end

   logic v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      out_ru    <= SUM_W'(mu_ff >> SH);
      out_rv    <= SUM_W'(mv_ff >> SH);
      out_den   <= mw_ff;
      out_lqu   <= {mu_ff[SH-1:0], FR'(0)};
      out_lqv   <= {mv_ff[SH-1:0], FR'(0)};
      out_ctl_u <= '{neg: su_ff ^ sw_ff, sat: ((SUM_W+SH)'(mu_ff) >= den_sh)};
      out_ctl_v <= '{neg: sv_ff ^ sw_ff, sat: ((SUM_W+SH)'(mv_ff) >= den_sh)};
      out_flags <= '{in_square: in_u && in_v && !zw_ff, bad: zw_ff};
   end

   assign out_valid = v4_ff;

endmodule

[rtl/homp_div_step.sv]
// ----------------------------------------------------------------------------
// homp_div_step: one registered step of restoring division.
// Shifts one dividend bit into the remainder and one quotient bit out.
// ----------------------------------------------------------------------------
module homp_div_step #(
   parameter int SUM_W = homp_pkg::COEF_W + homp_pkg::COORD_BITS_DEF + 2
) (
   input  logic                          clock,
   input  logic [SUM_W-1:0]              in_r,
   input  logic [SUM_W-1:0]              in_d,
   input  logic [homp_pkg::OUT_W-1:0]    in_lq,
   output logic [SUM_W-1:0]              out_r,
   output logic [SUM_W-1:0]              out_d,
   output logic [homp_pkg::OUT_W-1:0]    out_lq
);

   logic [SUM_W:0] trial;
   logic           ge;

   always_comb begin
      trial = {in_r, in_lq[homp_pkg::OUT_W-1]};
      ge    = (trial >= {1'b0, in_d});
   end

   always_ff @(posedge clock) begin
      out_r  <= ge ? SUM_W'(trial - {1'b0, in_d}) : SUM_W'(trial);
      out_d  <= in_d;
      out_lq <= {in_lq[homp_pkg::OUT_W-2:0], ge};
   end

endmodule

[rtl/homp_divider.sv]
// ----------------------------------------------------------------------------
// homp_divider: pipelined restoring divider, one quotient bit per stage.
// Delivers the OUT_W-bit quotient from a chain of registered steps.
// ----------------------------------------------------------------------------
module homp_divider #(
   parameter int SUM_W = homp_pkg::COEF_W + homp_pkg::COORD_BITS_DEF + 2
) (
   input  logic                          clock,
   input  logic [SUM_W-1:0]              in_r,
   input  logic [SUM_W-1:0]              in_d,
   input  logic [homp_pkg::OUT_W-1:0]    in_lq,
   output logic [homp_pkg::OUT_W-1:0]    out_q
);

   localparam int N = homp_pkg::DIV_STEPS;

   logic [SUM_W-1:0]           r_s  [N+1];
   logic [SUM_W-1:0]           d_s  [N+1];
   logic [homp_pkg::OUT_W-1:0] lq_s [N+1];

   assign r_s[0]  = in_r;
   assign d_s[0]  = in_d;
   assign lq_s[0] = in_lq;

   for (genvar i = 0; i < N; i++) begin : g_step
      homp_div_step #(.SUM_W(SUM_W)) u_step (
         .clock  (clock),
         .in_r   (r_s[i]),
         .in_d   (d_s[i]),
         .in_lq  (lq_s[i]),
         .out_r  (r_s[i+1]),
         .out_d  (d_s[i+1]),
         .out_lq (lq_s[i+1])
      );
   end

   assign out_q = lq_s[N];

endmodule

[rtl/homography_point_map_unit.sv]
// ----------------------------------------------------------------------------
// homography_point_map_unit: projective 3x3 point transform.
// Maps (px,py) to saturated Q8.24 (u,v) with unit-square and zero-w flags.
// ----------------------------------------------------------------------------
// This unit takes one point per clock, every clock outside reset, and
// returns its result as a one-cycle beat on rsp_strobe; the receiver
// cannot hold results off, so it must capture every beat. A point passes
// through the front end (multiply, sum, magnitude, compare: four stages),
// the two parallel divide pipelines that produce one quotient bit per stage
// (32 stages), and one output register. busy is high only during reset.
// The coefficient registers are written through the csr_ port and must only
// change while no point is in flight; each write takes effect at once.
// u and v are the exact quotients times 2^24 truncated toward zero and
// saturated to 32 bits; inside_res is decided on the exact rational values.
// When the denominator is zero, bad_denominator is set and u, v and
// inside_res are all zero.
// ----------------------------------------------------------------------------
module homography_point_map_unit #(
   parameter int COORD_BITS = homp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = homp_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Point input.
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_BITS-1:0]       req_px,
   input  logic signed [COORD_BITS-1:0]       req_py,
   // Result output.
   output logic                               rsp_strobe,
   output logic signed [homp_pkg::OUT_W-1:0]  rsp_u_coord,
   output logic signed [homp_pkg::OUT_W-1:0]  rsp_v_coord,
   output logic                               rsp_inside_res,
   output logic                               rsp_bad_denominator,
   // Coefficient write port.
   input  logic                               csr_we,
   input  logic [homp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [homp_pkg::COEF_W-1:0]        csr_wdata
);

   // Sum of two products and a constant needs two guard bits.
   localparam int SUM_W = homp_pkg::COEF_W + COORD_BITS + 2;
   localparam int N     = homp_pkg::DIV_STEPS;
   localparam int OW    = homp_pkg::OUT_W;
   localparam logic [homp_pkg::COEF_W-1:0] COEF_ONE = homp_pkg::COEF_W'(1) << FRAC_BITS;
   localparam logic [homp_pkg::COEF_W-1:0] COEF_ZERO = '0;
   // Reset matrix is the identity; entries listed from m21 down to m00.
   localparam logic [homp_pkg::NUM_COEF-1:0][homp_pkg::COEF_W-1:0] COEF_RST =
      {{3{COEF_ZERO}}, COEF_ONE, {3{COEF_ZERO}}, COEF_ONE};
   localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
   localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};

   // No backpressure: a point is taken every cycle outside reset.
   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // Coefficient registers.
   logic [homp_pkg::NUM_COEF-1:0][homp_pkg::COEF_W-1:0] coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RST;
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Front end: products, sums, magnitudes and divider setup.
   logic                     f_valid;
   logic [SUM_W-1:0]         f_ru, f_rv, f_den;
   logic [OW-1:0]            f_lqu, f_lqv;
   homp_pkg::homp_ctl_type   f_ctl_u, f_ctl_v;
   homp_pkg::homp_flags_type f_flags;

   homp_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .SUM_W      (SUM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_px     (req_px),
      .in_py     (req_py),
      .coef      (coef_ff),
      .out_valid (f_valid),
      .out_ru    (f_ru),
      .out_rv    (f_rv),
      .out_den   (f_den),
      .out_lqu   (f_lqu),
      .out_lqv   (f_lqv),
      .out_ctl_u (f_ctl_u),
      .out_ctl_v (f_ctl_v),
      .out_flags (f_flags)
   );

   // Two divide pipelines share the denominator value.
   logic [OW-1:0] q_u, q_v;

   homp_divider #(.SUM_W(SUM_W)) u_div_u (
      .clock (clock),
      .in_r  (f_ru),
      .in_d  (f_den),
      .in_lq (f_lqu),
      .out_q (q_u)
   );

   homp_divider #(.SUM_W(SUM_W)) u_div_v (
      .clock (clock),
      .in_r  (f_rv),
      .in_d  (f_den),
      .in_lq (f_lqv),
      .out_q (q_v)
   );

   // Valid bits and per-point control travel alongside the dividers.
   logic                     dv_ff    [N];
   homp_pkg::homp_ctl_type   dctl_u_ff[N];
   homp_pkg::homp_ctl_type   dctl_v_ff[N];
   homp_pkg::homp_flags_type dflg_ff  [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else begin
         dv_ff[0] <= f_valid;
         for (int i = 1; i < N; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
      dctl_u_ff[0] <= f_ctl_u;
      dctl_v_ff[0] <= f_ctl_v;
      dflg_ff[0]   <= f_flags;
      for (int i = 1; i < N; i++) begin
         dctl_u_ff[i] <= dctl_u_ff[i-1];
         dctl_v_ff[i] <= dctl_v_ff[i-1];
         dflg_ff[i]   <= dflg_ff[i-1];
      end
   end

   // Sign and saturation. A negative result saturates once the magnitude
   // reaches 2^31; a positive one once it exceeds 2^31 - 1.
   function automatic logic [OW-1:0] fix_sign(input logic [OW-1:0] q,
                                              input homp_pkg::homp_ctl_type c);
      logic [OW-1:0] r;
      if (c.sat) begin
         r = c.neg ? SAT_NEG : SAT_POS;
      end else if (c.neg) begin
         r = q[OW-1] ? SAT_NEG : OW'(-q);
      end else begin
         r = q[OW-1] ? SAT_POS : q;
      end
      return r;
   endfunction

   logic [OW-1:0] u_in, v_in;
   homp_pkg::homp_flags_type last_flg;

   always_comb begin
      last_flg = dflg_ff[N-1];
      if (last_flg.bad) begin
         u_in = '0;
         v_in = '0;
      end else begin
         u_in = fix_sign(q_u, dctl_u_ff[N-1]);
         v_in = fix_sign(q_v, dctl_v_ff[N-1]);
      end
   end

   // Output register.
   logic          strobe_ff;
   logic [OW-1:0] u_ff, v_ff;
   logic          inside_ff, bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_ff[N-1];
      end
      u_ff      <= u_in;
      v_ff      <= v_in;
      inside_ff <= last_flg.in_square;
      bad_ff    <= last_flg.bad;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_u_coord         = u_ff;
   assign rsp_v_coord         = v_ff;
   assign rsp_inside_res      = inside_ff;
   assign rsp_bad_denominator = bad_ff;

   // A zero denominator never reports a point inside the square.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_bad_denominator && rsp_inside_res))
      else $error("inside reported with zero denominator");

   // A zero denominator clears both coordinates.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bad_denominator) |-> (rsp_u_coord == '0 && rsp_v_coord == '0))
      else $error("coordinates not cleared on zero denominator");

   // A point inside the unit square maps to coordinates between 0 and 1.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_inside_res) |->
         (!rsp_u_coord[OW-1] && rsp_u_coord <= (OW'(1) << homp_pkg::OUT_FRAC) &&
          !rsp_v_coord[OW-1] && rsp_v_coord <= (OW'(1) << homp_pkg::OUT_FRAC)))
      else $error("inside point outside the unit range");

endmodule
